/* design/admm_node_ridge_solve_macros.svh */
// assertion macros for the admm node ridge solver
`ifndef ADMM_NODE_RIDGE_SOLVE_MACROS_SVH
`define ADMM_NODE_RIDGE_SOLVE_MACROS_SVH

// check on every clock once reset is released
`define ANRS_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock, reset included
`define ANRS_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/anrs_pkg.sv */
// shared types, constants, helpers and microcode for the node ridge solver
`default_nettype none
package anrs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 63;
  localparam int MAG_W     = 62;
  localparam int DVD_W     = MAG_W + FRAC_BITS;
  localparam int PRD_W     = 2 * MAG_W;
  localparam int CFG_W     = 31;
  localparam int COST_W    = 47;
  localparam int CIDX_W    = 8;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [CFG_W-1:0]        cfg_t;
  typedef logic [CIDX_W-1:0]       cidx_t;

  localparam mag_t LIM   = {MAG_W{1'b1}};
  localparam val_t VMAX  = {1'b0, LIM};
  localparam val_t VMIN  = -VMAX;
  localparam val_t VONE  = val_t'(1) <<< FRAC_BITS;
  localparam val_t VZERO = '0;

  localparam cfg_t INV_STEP_RST = CFG_W'(((64'd100 << FRAC_BITS) + 64'd3) / 64'd6);
  localparam cfg_t RIDGE_RST    = CFG_W'(64'd1 << (FRAC_BITS - 1));

  localparam cidx_t REG_INV_STEP = 8'd0;
  localparam cidx_t REG_RIDGE    = 8'd1;

  typedef struct packed {
    logic signed [31:0] feature_a;
    logic signed [31:0] feature_b;
    logic signed [31:0] feature_c;
    logic signed [31:0] target;
    logic signed [31:0] prev_w0;
    logic signed [31:0] prev_w1;
    logic signed [31:0] prev_w2;
    logic signed [31:0] prev_w3;
    logic signed [31:0] dual_sum0;
    logic signed [31:0] dual_sum1;
    logic signed [31:0] dual_sum2;
    logic signed [31:0] dual_sum3;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_w0;
    logic signed [31:0] new_w1;
    logic signed [31:0] new_w2;
    logic signed [31:0] new_w3;
    logic [COST_W-1:0]  node_cost;
  } out_t;

  typedef struct packed {
    logic go;
    val_t a;
    val_t b;
  } unit_req_t;

  typedef struct packed {
    logic done;
    val_t res;
  } unit_rsp_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_CLW,
    OP_CST
  } op_e;

  localparam int RF_DEPTH = 64;
  localparam int AD_W     = $clog2(RF_DEPTH);
  typedef logic [AD_W-1:0] addr_t;

  // register file map
  localparam addr_t AD_D0   = 6'd0;
  localparam addr_t AD_TGT  = 6'd4;
  localparam addr_t AD_RS   = 6'd5;
  localparam addr_t AD_MU   = 6'd6;
  localparam addr_t AD_XP0  = 6'd7;
  localparam addr_t AD_DU0  = 6'd11;
  localparam addr_t AD_ZERO = 6'd15;
  localparam addr_t AD_A0   = 6'd16;
  localparam addr_t AD_RHS0 = 6'd32;
  localparam addr_t AD_X0   = 6'd36;
  localparam addr_t AD_W0   = 6'd40;
  localparam addr_t AD_P    = 6'd44;
  localparam addr_t AD_T    = 6'd45;
  localparam addr_t AD_RAT  = 6'd46;
  localparam addr_t AD_COST = 6'd47;
  localparam addr_t AD_REG  = 6'd48;
  localparam addr_t AD_MU2  = 6'd49;

  localparam int NUM_LOAD = 16;
  localparam int LD_W     = $clog2(NUM_LOAD);

  typedef struct packed {
    op_e   op;
    addr_t dst;
    addr_t sa;
    addr_t sb;
  } uop_t;

  localparam int UCODE_N = 150;
  localparam int PC_W    = $clog2(UCODE_N);
  typedef uop_t [UCODE_N-1:0] prog_t;

  function automatic mag_t mag_of(val_t v);
    val_t n;
    n = -v;
    return v < 0 ? mag_t'(n) : mag_t'(v);
  endfunction

  function automatic val_t apply_sign(mag_t m, logic neg);
    val_t v;
    v = {1'b0, m};
    return neg ? -v : v;
  endfunction

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [VAL_W:0] s;
    s = a + b;
    if (s > VMAX) return VMAX;
    if (s < VMIN) return VMIN;
    return val_t'(s);
  endfunction

  function automatic addr_t off(addr_t base, int i);
    return addr_t'(int'(base) + i);
  endfunction

  function automatic addr_t ad_a(int j, int k);
    return addr_t'(int'(AD_A0) + 4 * j + k);
  endfunction

  function automatic uop_t mk(op_e o, addr_t d, addr_t a, addr_t b);
    uop_t u;
    u.op  = o;
    u.dst = d;
    u.sa  = a;
    u.sb  = b;
    return u;
  endfunction

  function automatic prog_t build_ucode();
    prog_t p;
    int n;
    int j;
    int k;
    int c;
    p = '0;
    n = 0;
    p[n] = mk(OP_ADD, AD_MU2, AD_MU, AD_MU); n++;
    // system matrix
    for (j = 0; j < 4; j++) begin
      for (k = 0; k < 4; k++) begin
        p[n] = mk(OP_MUL, AD_P, off(AD_D0, j), off(AD_D0, k)); n++;
        p[n] = mk(OP_ADD, ad_a(j, k), AD_P, AD_P); n++;
      end
    end
    for (j = 0; j < 4; j++) begin
      if (j < 3) begin
        p[n] = mk(OP_ADD, ad_a(j, j), ad_a(j, j), AD_MU2); n++;
      end
      p[n] = mk(OP_ADD, ad_a(j, j), ad_a(j, j), AD_RS); n++;
    end
    // right hand side
    for (j = 0; j < 4; j++) begin
      p[n] = mk(OP_MUL, AD_P, off(AD_D0, j), AD_TGT); n++;
      p[n] = mk(OP_ADD, off(AD_RHS0, j), AD_P, AD_P); n++;
      p[n] = mk(OP_MUL, AD_T, AD_RS, off(AD_XP0, j)); n++;
      p[n] = mk(OP_ADD, off(AD_RHS0, j), off(AD_RHS0, j), AD_T); n++;
      p[n] = mk(OP_SUB, off(AD_RHS0, j), off(AD_RHS0, j), off(AD_DU0, j)); n++;
    end
    // forward elimination
    for (k = 0; k < 4; k++) begin
      for (j = k + 1; j < 4; j++) begin
        p[n] = mk(OP_DIV, AD_RAT, ad_a(j, k), ad_a(k, k)); n++;
        for (c = k + 1; c < 4; c++) begin
          p[n] = mk(OP_MUL, AD_T, AD_RAT, ad_a(k, c)); n++;
          p[n] = mk(OP_SUB, ad_a(j, c), ad_a(j, c), AD_T); n++;
        end
        p[n] = mk(OP_MUL, AD_T, AD_RAT, off(AD_RHS0, k)); n++;
        p[n] = mk(OP_SUB, off(AD_RHS0, j), off(AD_RHS0, j), AD_T); n++;
      end
    end
    // back substitution
    for (j = 3; j >= 0; j--) begin
      for (k = j + 1; k < 4; k++) begin
        p[n] = mk(OP_MUL, AD_T, ad_a(j, k), off(AD_X0, k)); n++;
        p[n] = mk(OP_SUB, off(AD_RHS0, j), off(AD_RHS0, j), AD_T); n++;
      end
      p[n] = mk(OP_DIV, off(AD_X0, j), off(AD_RHS0, j), ad_a(j, j)); n++;
    end
    // cost
    for (j = 0; j < 4; j++) begin
      p[n] = mk(OP_CLW, off(AD_W0, j), off(AD_X0, j), off(AD_X0, j)); n++;
      p[n] = mk(OP_MUL, AD_P, off(AD_W0, j), off(AD_W0, j)); n++;
      p[n] = mk(OP_MUL, AD_T, AD_MU, AD_P); n++;
      p[n] = mk(OP_ADD, AD_COST, (j == 0) ? AD_ZERO : AD_COST, AD_T); n++;
      p[n] = mk(OP_MUL, AD_T, off(AD_D0, j), off(AD_W0, j)); n++;
      p[n] = mk(OP_ADD, AD_REG, (j == 0) ? AD_ZERO : AD_REG, AD_T); n++;
    end
    p[n] = mk(OP_SUB, AD_REG, AD_REG, AD_TGT); n++;
    p[n] = mk(OP_MUL, AD_P, AD_REG, AD_REG); n++;
    p[n] = mk(OP_ADD, AD_COST, AD_COST, AD_P); n++;
    p[n] = mk(OP_CST, AD_COST, AD_COST, AD_COST);
    return p;
  endfunction

  localparam prog_t UCODE = build_ucode();

endpackage
`default_nettype wire

/* design/anrs_mulu.sv */
// fixed point multiplier built from four 32x32 partial products
`default_nettype none
module anrs_mulu (
  input  wire                   clk,
  input  wire                   rst_n,
  input  anrs_pkg::unit_req_t   req,
  output anrs_pkg::unit_rsp_t   rsp
);
  import anrs_pkg::*;

  logic             busy_r;
  logic [2:0]       cnt_r;
  mag_t             xm_r;
  mag_t             ym_r;
  logic             neg_r;
  logic [PRD_W-1:0] acc_r;
  val_t             res_r;
  logic             done_r;

  logic [31:0]      hx;
  logic [31:0]      hy;
  logic [63:0]      pp;
  logic [PRD_W-1:0] sh;
  logic [PRD_W-1:0] rnd;
  logic [PRD_W-1:0] qv;
  mag_t             m;

  always_comb begin
    hx = cnt_r[1] ? {{(64 - MAG_W){1'b0}}, xm_r[MAG_W-1:32]} : xm_r[31:0];
    hy = cnt_r[0] ? {{(64 - MAG_W){1'b0}}, ym_r[MAG_W-1:32]} : ym_r[31:0];
    pp = hx * hy;
    case (cnt_r)
      3'd0:    sh = PRD_W'(pp);
      3'd1:    sh = PRD_W'(pp) << 32;
      3'd2:    sh = PRD_W'(pp) << 32;
      3'd3:    sh = PRD_W'(pp) << 64;
      default: sh = '0;
    endcase
    // round half away from zero on the magnitude
    rnd = acc_r + (PRD_W'(1) << (FRAC_BITS - 1));
    qv  = rnd >> FRAC_BITS;
    m   = (qv > PRD_W'(LIM)) ? LIM : qv[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      xm_r  <= mag_of(req.a);
      ym_r  <= mag_of(req.b);
      neg_r <= (req.a < 0) != (req.b < 0);
      acc_r <= '0;
    end else if (busy_r && cnt_r != 3'd4) begin
      acc_r <= acc_r + sh;
    end
    if (busy_r && cnt_r == 3'd4) begin
      res_r <= apply_sign(m, neg_r);
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

/* design/anrs_divu.sv */
// fixed point divider, restoring, one quotient bit per clock
`default_nettype none
module anrs_divu (
  input  wire                   clk,
  input  wire                   rst_n,
  input  anrs_pkg::unit_req_t   req,
  output anrs_pkg::unit_rsp_t   rsp
);
  import anrs_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             fin_r;
  logic [CNT_W-1:0] cnt_r;
  mag_t             nb_r;
  logic [DVD_W-1:0] dvd_r;
  mag_t             rem_r;
  logic [DVD_W-1:0] quo_r;
  logic             neg_r;
  val_t             res_r;
  logic             done_r;

  logic [MAG_W:0]   t;
  logic [MAG_W:0]   t_sub;
  logic             ge;
  logic             up;
  logic [MAG_W:0]   q1;
  mag_t             m;
  mag_t             na;
  mag_t             nb;

  always_comb begin
    na    = mag_of(req.a);
    nb    = mag_of(req.b);
    t     = {rem_r, dvd_r[DVD_W-1]};
    t_sub = t - {1'b0, nb_r};
    ge    = t >= {1'b0, nb_r};
    up    = {rem_r, 1'b0} >= {1'b0, nb_r};
    q1    = {1'b0, quo_r[MAG_W-1:0]} + {{MAG_W{1'b0}}, up};
    if (quo_r > DVD_W'(LIM)) begin
      m = LIM;
    end else if (q1 > {1'b0, LIM}) begin
      m = LIM;
    end else begin
      m = q1[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (req.go) begin
        if (nb == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(DVD_W);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      nb_r  <= nb;
      dvd_r <= {na, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      quo_r <= '0;
      neg_r <= (req.a < 0) != (req.b < 0);
      // divide by zero: zero over zero is zero, else full scale with the numerator's sign
      res_r <= (na == '0) ? VZERO : apply_sign(LIM, req.a < 0);
    end else if (busy_r) begin
      rem_r <= ge ? t_sub[MAG_W-1:0] : t[MAG_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
      dvd_r <= dvd_r << 1;
    end else if (fin_r) begin
      res_r <= apply_sign(m, neg_r);
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

/* design/anrs_front.sv */
// front end: takes items and holds them in a two entry queue
`default_nettype none
module anrs_front (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  output logic            busy,
  input  anrs_pkg::in_t   in_item,
  input  wire             pop,
  output logic            head_valid,
  output anrs_pkg::in_t   head
);
  import anrs_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  in_t              q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             push;
  logic             take;

  assign busy       = cnt_r == (PTR_W + 1)'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = q_r[rd_ptr_r];
  assign push       = start && !busy;
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (take) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !take) cnt_r <= cnt_r + (PTR_W + 1)'(1);
      else if (take && !push) cnt_r <= cnt_r - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= in_item;
  end

endmodule
`default_nettype wire

/* design/anrs_back.sv */
// back end: microcoded sequencer over a register file with shared mul and div units
`default_nettype none
module anrs_back (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             head_valid,
  input  anrs_pkg::in_t   head,
  output logic            pop,
  input  anrs_pkg::cfg_t  inv_step,
  input  anrs_pkg::cfg_t  ridge_weight,
  output logic            out_strobe,
  output anrs_pkg::out_t  out_item
);
  import anrs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_EXEC,
    ST_MULW,
    ST_DIVW
  } state_t;

  localparam logic signed [31:0] I32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh80000000;
  localparam val_t CMAX = val_t'({COST_W{1'b1}});

  state_t          state_r;
  logic [PC_W-1:0] pc_r;
  logic [LD_W-1:0] ld_cnt_r;
  logic            out_strobe_r;
  out_t            out_r;
  val_t            rf_r [RF_DEPTH];
  val_t            rda_r;
  val_t            rdb_r;

  uop_t            uop;
  val_t            ld_val;
  val_t            alu_res;
  val_t            clw_res;
  val_t            cst_res;
  logic            wr_en;
  addr_t           wr_addr;
  val_t            wr_data;
  unit_req_t       mul_req;
  unit_req_t       div_req;
  unit_rsp_t       mul_rsp;
  unit_rsp_t       div_rsp;

  assign uop = UCODE[pc_r];

  anrs_mulu u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  anrs_divu u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    case (addr_t'(ld_cnt_r))
      AD_D0:              ld_val = val_t'(head.feature_a);
      off(AD_D0, 1):      ld_val = val_t'(head.feature_b);
      off(AD_D0, 2):      ld_val = val_t'(head.feature_c);
      off(AD_D0, 3):      ld_val = VONE;
      AD_TGT:             ld_val = val_t'(head.target);
      AD_RS:              ld_val = val_t'({1'b0, inv_step});
      AD_MU:              ld_val = val_t'({1'b0, ridge_weight});
      AD_XP0:             ld_val = val_t'(head.prev_w0);
      off(AD_XP0, 1):     ld_val = val_t'(head.prev_w1);
      off(AD_XP0, 2):     ld_val = val_t'(head.prev_w2);
      off(AD_XP0, 3):     ld_val = val_t'(head.prev_w3);
      AD_DU0:             ld_val = val_t'(head.dual_sum0);
      off(AD_DU0, 1):     ld_val = val_t'(head.dual_sum1);
      off(AD_DU0, 2):     ld_val = val_t'(head.dual_sum2);
      off(AD_DU0, 3):     ld_val = val_t'(head.dual_sum3);
      default:            ld_val = VZERO;
    endcase
  end

  always_comb begin
    if (rda_r > val_t'(I32_MAX))      clw_res = val_t'(I32_MAX);
    else if (rda_r < val_t'(I32_MIN)) clw_res = val_t'(I32_MIN);
    else                              clw_res = rda_r;
    if (rda_r < 0)         cst_res = VZERO;
    else if (rda_r > CMAX) cst_res = CMAX;
    else                   cst_res = rda_r;
    case (uop.op)
      OP_ADD:  alu_res = sat_add(rda_r, rdb_r);
      OP_SUB:  alu_res = sat_add(rda_r, -rdb_r);
      OP_CLW:  alu_res = clw_res;
      OP_CST:  alu_res = cst_res;
      default: alu_res = VZERO;
    endcase
  end

  always_comb begin
    mul_req.go = (state_r == ST_EXEC) && (uop.op == OP_MUL);
    mul_req.a  = rda_r;
    mul_req.b  = rdb_r;
    div_req.go = (state_r == ST_EXEC) && (uop.op == OP_DIV);
    div_req.a  = rda_r;
    div_req.b  = rdb_r;
    wr_en      = 1'b0;
    wr_addr    = uop.dst;
    wr_data    = alu_res;
    case (state_r)
      ST_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = addr_t'(ld_cnt_r);
        wr_data = ld_val;
      end
      ST_EXEC: begin
        wr_en = (uop.op != OP_MUL) && (uop.op != OP_DIV);
      end
      ST_MULW: begin
        wr_en   = mul_rsp.done;
        wr_data = mul_rsp.res;
      end
      ST_DIVW: begin
        wr_en   = div_rsp.done;
        wr_data = div_rsp.res;
      end
      default: ;
    endcase
  end

  assign pop = (state_r == ST_LOAD) && (ld_cnt_r == LD_W'(NUM_LOAD - 1));

  // register file, registered reads
  always_ff @(posedge clk) begin
    if (wr_en) rf_r[wr_addr] <= wr_data;
    rda_r <= rf_r[uop.sa];
    rdb_r <= rf_r[uop.sb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pc_r         <= '0;
      ld_cnt_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (head_valid) begin
            state_r  <= ST_LOAD;
            ld_cnt_r <= '0;
            pc_r     <= '0;
          end
        end
        ST_LOAD: begin
          ld_cnt_r <= ld_cnt_r + LD_W'(1);
          if (pop) state_r <= ST_READ;
        end
        ST_READ: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          case (uop.op)
            OP_MUL: state_r <= ST_MULW;
            OP_DIV: state_r <= ST_DIVW;
            OP_CST: begin
              state_r      <= ST_IDLE;
              out_strobe_r <= 1'b1;
            end
            default: begin
              state_r <= ST_READ;
              pc_r    <= pc_r + PC_W'(1);
            end
          endcase
        end
        ST_MULW: begin
          if (mul_rsp.done) begin
            state_r <= ST_READ;
            pc_r    <= pc_r + PC_W'(1);
          end
        end
        ST_DIVW: begin
          if (div_rsp.done) begin
            state_r <= ST_READ;
            pc_r    <= pc_r + PC_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result capture as the clamped weights and the cost are written back
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC && uop.op == OP_CLW) begin
      case (uop.dst)
        AD_W0:         out_r.new_w0 <= clw_res[31:0];
        off(AD_W0, 1): out_r.new_w1 <= clw_res[31:0];
        off(AD_W0, 2): out_r.new_w2 <= clw_res[31:0];
        off(AD_W0, 3): out_r.new_w3 <= clw_res[31:0];
        default: ;
      endcase
    end
    if (state_r == ST_EXEC && uop.op == OP_CST) begin
      out_r.node_cost <= cst_res[COST_W-1:0];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule
`default_nettype wire

/* design/admm_node_ridge_solve.sv */
// top level: config registers, front queue and solver back end
// with the back end idle, it takes the queue head, loads it into the register file, then runs
// 150 microcode steps of a read and an execute each, with 63 multiplies and 10 divides waiting
// on their units; items go one at a time, paced mostly by the serial divider, which a zero divisor bypasses
// a two item queue takes new items while one is being solved; busy is high when it is full
// synchronous active low reset clears control and loads the register defaults
`default_nettype none
module admm_node_ridge_solve (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  anrs_pkg::in_t          in_item,
  output logic                   out_strobe,
  output anrs_pkg::out_t         out_item,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  anrs_pkg::cidx_t        cfg_index,
  input  wire [31:0]             cfg_data
);
  import anrs_pkg::*;

  cfg_t inv_step_r;
  cfg_t ridge_r;
  logic head_valid;
  in_t  head;
  logic pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_step_r <= INV_STEP_RST;
      ridge_r    <= RIDGE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INV_STEP: inv_step_r <= cfg_data[CFG_W-1:0];
        REG_RIDGE:    ridge_r    <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  anrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  anrs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .inv_step     (inv_step_r),
    .ridge_weight (ridge_r),
    .out_strobe   (out_strobe),
    .out_item     (out_item)
  );

endmodule
`default_nettype wire

/* design/anrs_checker.sv */
// port level checks for the node ridge solver, bound to the top level
`default_nettype none
`include "admm_node_ridge_solve_macros.svh"
module anrs_checker (
  input wire             clk,
  input wire             rst_n,
  input wire             start,
  input wire             busy,
  input wire             out_strobe,
  input wire             cfg_ready
);

  // each result needs a full solve, so strobes never come back to back
  `ANRS_ASSERT_RUN(a_strobe_gap, out_strobe |=> !out_strobe, "result strobes back to back")
  // the queue fills only by taking an item
  `ANRS_ASSERT_RUN(a_busy_rise, $rose(busy) |-> $past(start), "busy rose with no item taken")
  // the config port never stalls
  `ANRS_ASSERT_RUN(a_cfg_ready, cfg_ready, "config port not ready")

endmodule

bind admm_node_ridge_solve anrs_checker u_anrs_checker (.*);
`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the admm node ridge solver
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import anrs_pkg::*;

  localparam longint unsigned SAT_MAG  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint          COST_TOP = 64'h7FFF_FFFF_FFFF;
  localparam longint          CYCLE_CAP = 64'd12_000_000;
  localparam int              N_DIRECTED = 9;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  in_t   in_item;
  logic  out_strobe;
  out_t  out_item;
  logic  cfg_valid;
  logic  cfg_ready;
  cidx_t cfg_index;
  logic [31:0] cfg_data;

  admm_node_ridge_solve DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // solver's copy of the two registers
  longint unsigned step_inv;
  longint unsigned mu_reg;

  out_t   pending_w[$];
  int     mismatches;
  longint cycles;
  int     send_idle_pct;
  in_t    directed[N_DIRECTED];
  logic   directed_known[N_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint with_sign(longint unsigned m, logic neg);
    if (m > SAT_MAG) m = SAT_MAG;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > longint'(SAT_MAG)) return longint'(SAT_MAG);
    if (s < -longint'(SAT_MAG)) return -longint'(SAT_MAG);
    return s;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    longint unsigned m;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    m = (p > 128'(SAT_MAG)) ? SAT_MAG : p[63:0];
    return with_sign(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_div(longint a, longint b);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic [127:0] r;
    longint unsigned m;
    if (b == 0) return (a == 0) ? 0 : with_sign(SAT_MAG, a < 0);
    num = {64'd0, mag64(a)} << FRAC_BITS;
    den = {64'd0, mag64(b)};
    q = num / den;
    r = num % den;
    if (2 * r >= den) q = q + 1;
    m = (q > 128'(SAT_MAG)) ? SAT_MAG : q[63:0];
    return with_sign(m, (a < 0) != (b < 0));
  endfunction

  function automatic out_t solve_node(in_t it);
    longint d[4];
    longint xp[4];
    longint du[4];
    longint a[4][4];
    longint rhs[4];
    longint x[4];
    longint w[4];
    longint tgt;
    longint rs;
    longint mu;
    longint p;
    longint ratio;
    longint s;
    longint resid;
    longint cost;
    out_t o;
    tgt = longint'(it.target);
    rs = longint'(step_inv);
    mu = longint'(mu_reg);
    d[0] = longint'(it.feature_a);
    d[1] = longint'(it.feature_b);
    d[2] = longint'(it.feature_c);
    d[3] = longint'(1) << FRAC_BITS;
    xp[0] = longint'(it.prev_w0);
    xp[1] = longint'(it.prev_w1);
    xp[2] = longint'(it.prev_w2);
    xp[3] = longint'(it.prev_w3);
    du[0] = longint'(it.dual_sum0);
    du[1] = longint'(it.dual_sum1);
    du[2] = longint'(it.dual_sum2);
    du[3] = longint'(it.dual_sum3);
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        p = q_mul(d[j], d[k]);
        a[j][k] = q_add(p, p);
      end
      if (j < 3) a[j][j] = q_add(a[j][j], q_add(mu, mu));
      a[j][j] = q_add(a[j][j], rs);
      p = q_mul(d[j], tgt);
      rhs[j] = q_add(q_add(p, p), q_mul(rs, xp[j]));
      rhs[j] = q_add(rhs[j], -du[j]);
    end
    for (int k = 0; k < 4; k++) begin
      for (int j = k + 1; j < 4; j++) begin
        ratio = q_div(a[j][k], a[k][k]);
        for (int c = k + 1; c < 4; c++) a[j][c] = q_add(a[j][c], -q_mul(ratio, a[k][c]));
        rhs[j] = q_add(rhs[j], -q_mul(ratio, rhs[k]));
      end
    end
    for (int j = 3; j >= 0; j--) begin
      s = rhs[j];
      for (int k = j + 1; k < 4; k++) s = q_add(s, -q_mul(a[j][k], x[k]));
      x[j] = q_div(s, a[j][j]);
    end
    cost = 0;
    resid = 0;
    for (int j = 0; j < 4; j++) begin
      w[j] = x[j];
      if (w[j] > 64'sh7FFF_FFFF) w[j] = 64'sh7FFF_FFFF;
      if (w[j] < -64'sh8000_0000) w[j] = -64'sh8000_0000;
      cost = q_add(cost, q_mul(mu, q_mul(w[j], w[j])));
      resid = q_add(resid, q_mul(d[j], w[j]));
    end
    resid = q_add(resid, -tgt);
    cost = q_add(cost, q_mul(resid, resid));
    if (cost < 0) cost = 0;
    if (cost > COST_TOP) cost = COST_TOP;
    o.new_w0 = w[0][31:0];
    o.new_w1 = w[1][31:0];
    o.new_w2 = w[2][31:0];
    o.new_w3 = w[3][31:0];
    o.node_cost = cost[COST_W-1:0];
    return o;
  endfunction

  // mostly moderate values so the solve stays meaningful, some full range and corners
  function automatic logic [31:0] pick_value(int mode);
    int sel;
    if (mode == 0) return 32'($signed(20'($urandom)));
    if (mode == 1) return $urandom;
    sel = $urandom_range(3);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic in_t rand_node();
    in_t it;
    logic [31:0] v[12];
    int r;
    int mode;
    r = $urandom_range(99);
    mode = (r < 70) ? 0 : (r < 90) ? 1 : 2;
    for (int i = 0; i < 12; i++) v[i] = pick_value(($urandom_range(9) == 0) ? 1 : mode);
    it = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
    return it;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // results cannot be held off, so check every strobe
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_strobe) begin
      if (pending_w.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected item out: %p", out_item);
      end else begin
        want = pending_w.pop_front();
        if (want.new_w0 !== out_item.new_w0 || want.new_w1 !== out_item.new_w1 ||
            want.new_w2 !== out_item.new_w2 || want.new_w3 !== out_item.new_w3 ||
            want.node_cost !== out_item.node_cost) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, out_item);
        end
      end
    end
  end

  task automatic send_node(in_t it, logic known, out_t typed);
    start <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_w.push_back(known ? typed : solve_node(it));
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_w.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cidx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    if (idx == REG_INV_STEP) step_inv = val[30:0];
    else if (idx == REG_RIDGE) mu_reg = val[30:0];
  endtask

  task automatic run_directed();
    for (int i = 0; i < N_DIRECTED; i++) send_node(directed[i], directed_known[i], '0);
    drain();
  endtask

  task automatic run_random(int count, int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      send_node(rand_node(), 1'b0, '0);
      if (i % 100 == 99) drain();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    step_inv = 64'd1092267;
    mu_reg = 64'd32768;

    // all-zero node solves to zero weights and zero cost under any setting
    directed[0] = '0;
    directed_known[0] = 1'b1;
    directed[1] = {12{32'h7FFF_FFFF}};
    directed[2] = {12{32'h8000_0000}};
    directed[3] = {{3{32'h7FFF_FFFF}}, 32'h8000_0000, {8{32'h0}}};
    directed[4] = {{3{32'h0}}, 32'h7FFF_FFFF, {4{32'h7FFF_FFFF}}, {4{32'h8000_0000}}};
    directed[5] = {32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000,
                   {4{32'h0001_0000}}, {4{32'hFFFF_8000}}};
    directed[6] = {32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0, {8{32'h0}}};
    directed[7] = {32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, {8{32'h0000_0001}}};
    directed[8] = {{4{32'h5555_5555}}, {4{32'hAAAA_AAAA}}, {4{32'h3333_CCCC}}};
    for (int i = 1; i < N_DIRECTED; i++) directed_known[i] = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // unknown indexes are ignored, top data bit is dropped
    write_reg(8'd2, 32'h1234_5678);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    write_reg(REG_INV_STEP, 32'h8000_0001);
    write_reg(REG_RIDGE, 32'h0);
    run_directed();

    write_reg(REG_INV_STEP, 32'hFFFF_FFFF);
    write_reg(REG_RIDGE, 32'hFFFF_FFFF);
    run_random(480, 8);

    write_reg(REG_INV_STEP, 32'($urandom_range(1, 32'h0010_0000)));
    write_reg(REG_RIDGE, 32'($urandom_range(0, 32'h0004_0000)));
    run_random(480, 57);

    write_reg(REG_INV_STEP, 32'd1092267);
    write_reg(REG_RIDGE, 32'd32768);
    run_random(470, 0);

    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_w.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/anrs_pkg.sv
design/anrs_mulu.sv
design/anrs_divu.sv
design/anrs_front.sv
design/anrs_back.sv
design/admm_node_ridge_solve.sv
design/anrs_checker.sv
tb/tb.sv
